[rtl/vmp_pkg.sv]
`timescale 1ns / 1ps
package vmp_pkg;

  localparam int unsigned POS_W   = 10;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned RGB_W   = 3 * CHAN_W;
  localparam int unsigned COUNT_W = 9;

  localparam logic [RGB_W-1:0] PINK_RGB = {8'd255, 8'd192, 8'd203};

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_CAPTURE = 2'd1,
    MODE_RENDER  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [IDX_W-1:0]  seed_index;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
  } pix_out_t;

  // Beat as it walks down the seed chain: the item plus the running winner.
  typedef struct packed {
    pix_in_t          pix;
    logic             found;
    logic [RGB_W-1:0] best_rgb;
  } chain_beat_t;

endpackage

[rtl/vmp_cell.sv]
`timescale 1ns / 1ps
module vmp_cell
  import vmp_pkg::*;
#(
  parameter int unsigned CELL_ID    = 0,
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic [COUNT_W-1:0]      seed_count_i,
  input  logic                    vld_i,
  input  chain_beat_t             beat_i,
  input  logic [COORD_BITS-1:0]   px_i,
  input  logic [COORD_BITS-1:0]   py_i,
  input  logic [2*COORD_BITS:0]   dist_i,
  output logic                    vld_o,
  output chain_beat_t             beat_o,
  output logic [COORD_BITS-1:0]   px_o,
  output logic [COORD_BITS-1:0]   py_o,
  output logic [2*COORD_BITS:0]   dist_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned SQ_W = 2 * CB;
  localparam int unsigned DW = 2 * CB + 1;

  logic [CB-1:0]    col_q, row_q;
  logic [RGB_W-1:0] rgb_q;

  logic             a_vld_q, b_vld_q;
  chain_beat_t      a_beat_q, b_beat_q;
  logic [CB-1:0]    a_px_q, a_py_q, b_px_q, b_py_q;
  logic [DW-1:0]    a_dist_q, b_dist_q;
  logic [SQ_W-1:0]  a_sqx_q, a_sqy_q;

  logic             active;
  logic [CB-1:0]    dx, dy;
  logic [SQ_W-1:0]  sqx_d, sqy_d;
  logic [DW-1:0]    d;
  logic             take;
  chain_beat_t      b_beat_d;
  logic [DW-1:0]    b_dist_d;

  assign active = CELL_ID < 32'(seed_count_i);

  // Stage A: squared axis distances against the stored seed.
  assign dx    = (col_q >= px_i) ? (col_q - px_i) : (px_i - col_q);
  assign dy    = (row_q >= py_i) ? (row_q - py_i) : (py_i - row_q);
  assign sqx_d = {{CB{1'b0}}, dx} * {{CB{1'b0}}, dx};
  assign sqy_d = {{CB{1'b0}}, dy} * {{CB{1'b0}}, dy};

  // Stage B: sum and compare; strict less keeps the lower index on a tie.
  assign d    = {1'b0, a_sqx_q} + {1'b0, a_sqy_q};
  assign take = a_vld_q && (a_beat_q.pix.mode == MODE_RENDER) && active &&
                (!a_beat_q.found || (d < a_dist_q));

  always_comb begin
    b_beat_d = a_beat_q;
    b_dist_d = a_dist_q;
    if (take) begin
      b_beat_d.found    = 1'b1;
      b_beat_d.best_rgb = rgb_q;
      b_dist_d          = d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= vld_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_beat_q <= beat_i;
      a_px_q   <= px_i;
      a_py_q   <= py_i;
      a_dist_q <= dist_i;
      a_sqx_q  <= sqx_d;
      a_sqy_q  <= sqy_d;
      b_beat_q <= b_beat_d;
      b_px_q   <= a_px_q;
      b_py_q   <= a_py_q;
      b_dist_q <= b_dist_d;
      if (vld_i && (beat_i.pix.mode == MODE_LOAD) &&
          (32'(beat_i.pix.seed_index) == CELL_ID)) begin
        col_q <= px_i;
        row_q <= py_i;
      end
      if (vld_i && (beat_i.pix.mode == MODE_CAPTURE) && active &&
          (col_q == px_i) && (row_q == py_i)) begin
        rgb_q <= {beat_i.pix.in_red, beat_i.pix.in_green, beat_i.pix.in_blue};
      end
    end
  end

  assign vld_o  = b_vld_q;
  assign beat_o = b_beat_q;
  assign px_o   = b_px_q;
  assign py_o   = b_py_q;
  assign dist_o = b_dist_q;

endmodule

[rtl/voronoi_mosaic_pixel_top.sv]
`timescale 1ns / 1ps
// Voronoi mosaic filter built as a chain of MAX_SEEDS seed cells, cell k holding
// the position and captured colour of seed k. Every beat (load, capture or
// render) enters cell 0 and moves one cell stage per cycle while the chain is
// not stalled, two stages per cell, so a new beat is taken every cycle unless
// in_stall_o is high, and beats stay in order: a load or capture always lands
// before any later render sees that seed. A render beat passes the stage A
// and stage B registers of every cell to the tail of the chain and is then
// loaded into the output register; load and capture beats give no result.
// The chain moves as a whole: a stalled result in the output register
// freezes every cell and raises in_stall_o. With no seeds in use a render
// answers pink (255,192,203); on equal distances the lower seed index wins.
// Write seed_count only while the chain is empty. Seed storage has no reset
// and must be loaded and captured before it is rendered against.
module voronoi_mosaic_pixel_top
  import vmp_pkg::*;
#(
  parameter int unsigned MAX_SEEDS  = 256,
  parameter int unsigned COORD_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pix_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pix_out_t           out_data_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DW = 2 * CB + 1;

  logic [COUNT_W-1:0] seed_count_q;
  logic               advance;

  logic               vld_c  [MAX_SEEDS+1];
  chain_beat_t        beat_c [MAX_SEEDS+1];
  logic [CB-1:0]      px_c   [MAX_SEEDS+1];
  logic [CB-1:0]      py_c   [MAX_SEEDS+1];
  logic [DW-1:0]      dist_c [MAX_SEEDS+1];

  logic               out_valid_q, out_valid_d;
  pix_out_t           out_data_q;
  logic               tail_render;

  // Move the whole chain unless a finished result is held by the sink.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_count_q <= '0;
    end else if (cfg_we_i) begin
      seed_count_q <= cfg_wdata_i;
    end
  end

  // Wrap or widen the incoming coordinates to COORD_BITS.
  generate
    if (CB <= POS_W) begin : g_wrap
      assign px_c[0] = in_data_i.pos_x[CB-1:0];
      assign py_c[0] = in_data_i.pos_y[CB-1:0];
    end else begin : g_widen
      assign px_c[0] = {{(CB-POS_W){1'b0}}, in_data_i.pos_x};
      assign py_c[0] = {{(CB-POS_W){1'b0}}, in_data_i.pos_y};
    end
  endgenerate

  // Head of the chain: no seed found yet, default colour pink.
  assign vld_c[0]           = in_valid_i;
  assign beat_c[0].pix      = in_data_i;
  assign beat_c[0].found    = 1'b0;
  assign beat_c[0].best_rgb = PINK_RGB;
  assign dist_c[0]          = '0;

  generate
    for (genvar k = 0; k < MAX_SEEDS; k++) begin : g_cell
      vmp_cell #(
        .CELL_ID    (k),
        .COORD_BITS (CB)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .en_i         (advance),
        .seed_count_i (seed_count_q),
        .vld_i        (vld_c[k]),
        .beat_i       (beat_c[k]),
        .px_i         (px_c[k]),
        .py_i         (py_c[k]),
        .dist_i       (dist_c[k]),
        .vld_o        (vld_c[k+1]),
        .beat_o       (beat_c[k+1]),
        .px_o         (px_c[k+1]),
        .py_o         (py_c[k+1]),
        .dist_o       (dist_c[k+1])
      );
    end
  endgenerate

  // Only render beats leaving the tail produce a result.
  assign tail_render = vld_c[MAX_SEEDS] &&
                       (beat_c[MAX_SEEDS].pix.mode == MODE_RENDER);

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = tail_render;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && tail_render) begin
      out_data_q <= beat_c[MAX_SEEDS].best_rgb;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Keep the spare coordinate and distance taps of the last cell in use.
  logic tail_unused;
  assign tail_unused = ^{px_c[MAX_SEEDS], py_c[MAX_SEEDS], dist_c[MAX_SEEDS],
                         beat_c[MAX_SEEDS].found};

endmodule

[rtl/vmp_checker.sv]
`timescale 1ns / 1ps
module vmp_checker
  import vmp_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input pix_out_t out_data_o
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Stall the input exactly when a result is held back.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output backpressure");

  // Once reset has been seen at an edge, stay idle on the next one.
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("result or stall shown during reset");

endmodule

bind voronoi_mosaic_pixel_top vmp_checker u_vmp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[bench/tb_voronoi_mosaic_pixel_top.sv]
`timescale 1ns / 1ps
module tb_voronoi_mosaic_pixel_top;
  import vmp_pkg::*;

  localparam int unsigned NUM_SEEDS   = 256;
  localparam int unsigned COORD_W     = 10;
  // Delay from an accepted beat to its render result, used to drain the chain.
  localparam int unsigned LATENCY     = 2 * NUM_SEEDS;
  localparam int unsigned ITEM_TARGET = 750;
  localparam int unsigned POOL_SIZE   = 12;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam pix_out_t    PINK        = '{out_red: 8'd255, out_green: 8'd192, out_blue: 8'd203};

  // One row of the directed table: a register write, or a beat with an
  // optional hand-typed answer.
  typedef struct {
    bit                 is_cfg;
    logic [COUNT_W-1:0] cfg_val;
    pix_in_t            beat;
    bit                 typed;
    pix_out_t           want;
  } stim_row_t;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  pix_in_t            in_data   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  pix_out_t           out_data;

  // Own copy of the seed store and of the seed count register.
  logic [POS_W-1:0]   seed_x     [NUM_SEEDS];
  logic [POS_W-1:0]   seed_y     [NUM_SEEDS];
  logic [RGB_W-1:0]   seed_color [NUM_SEEDS];
  logic [COUNT_W-1:0] seed_count_q = '0;

  pix_out_t           pending_colors [$];
  stim_row_t          rows [$];
  int unsigned        fails      = 0;
  int unsigned        beats_sent = 0;
  bit                 in_steady  = 1'b0;
  int unsigned        stall_left = 0;
  bit                 stall_now  = 1'b0;

  voronoi_mosaic_pixel_top #(
    .MAX_SEEDS  (NUM_SEEDS),
    .COORD_BITS (COORD_W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned seeds_in_use();
    return (seed_count_q > NUM_SEEDS) ? NUM_SEEDS : int'(seed_count_q);
  endfunction

  // Advance the seed store by one beat; return 1 with the nearest seed color
  // for a render beat. Ties keep the lower index since only a strictly
  // smaller distance replaces the running winner.
  function automatic bit apply_beat(input pix_in_t b, output pix_out_t color);
    int unsigned      n;
    int unsigned      d;
    int unsigned      best;
    int               dx;
    int               dy;
    bit               found;
    logic [RGB_W-1:0] rgb;
    n     = seeds_in_use();
    color = PINK;
    case (b.mode)
      MODE_LOAD: begin
        seed_x[b.seed_index] = b.pos_x;
        seed_y[b.seed_index] = b.pos_y;
        return 1'b0;
      end
      MODE_CAPTURE: begin
        for (int i = 0; i < n; i++) begin
          if (seed_x[i] == b.pos_x && seed_y[i] == b.pos_y) begin
            seed_color[i] = {b.in_red, b.in_green, b.in_blue};
          end
        end
        return 1'b0;
      end
      MODE_RENDER: begin
        found = 1'b0;
        best  = 0;
        rgb   = PINK;
        for (int i = 0; i < n; i++) begin
          dx = int'(seed_x[i]) - int'(b.pos_x);
          dy = int'(seed_y[i]) - int'(b.pos_y);
          d  = dx * dx + dy * dy;
          if (!found || d < best) begin
            found = 1'b1;
            best  = d;
            rgb   = seed_color[i];
          end
        end
        color = rgb;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic pix_in_t mk_beat(input logic [1:0] mode, input logic [IDX_W-1:0] idx,
                                      input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                      input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] bl);
    return '{mode: mode, seed_index: idx, pos_x: x, pos_y: y,
             in_red: r, in_green: g, in_blue: bl};
  endfunction

  function automatic pix_in_t rand_beat();
    return pix_in_t'($bits(pix_in_t)'({$urandom, $urandom}));
  endfunction

  // Bias coordinates toward both edges of the frame.
  function automatic logic [POS_W-1:0] rand_pos();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return POS_MAX;
    return POS_W'($urandom_range(0, POS_MAX));
  endfunction

  // Mostly back-to-back beats, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (in_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  task automatic push_item(input pix_in_t b, input bit typed, input pix_out_t want);
    stim_row_t row;
    row.is_cfg  = 1'b0;
    row.cfg_val = '0;
    row.beat    = b;
    row.typed   = typed;
    row.want    = want;
    rows.insert(rows.size(), row);
  endtask

  task automatic push_cfg(input logic [COUNT_W-1:0] value);
    stim_row_t row;
    row.is_cfg  = 1'b1;
    row.cfg_val = value;
    row.beat    = '0;
    row.typed   = 1'b0;
    row.want    = PINK;
    rows.insert(rows.size(), row);
  endtask

  // Present one beat after an optional gap and hold it until accepted, then
  // record the color it must produce. Signals are read in the active region
  // right after the edge, so they still hold their pre-edge values.
  task automatic send_beat(input pix_in_t b, input int unsigned gap, input bit typed,
                           input pix_out_t want);
    pix_out_t color;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (apply_beat(b, color)) pending_colors.insert(pending_colors.size(), typed ? want : color);
    if (b.mode != MODE_UNUSED) beats_sent++;
  endtask

  // Write the seed count only with the chain empty: drain all renders, then
  // let loads and captures still in flight fall out of the chain.
  task automatic write_seed_count(input logic [COUNT_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we       <= 1'b0;
    seed_count_q = value;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fails++;
    end
  endtask

  // Output side: check each accepted result against the oldest expected
  // color, then pick the stall for the next cycle.
  always @(posedge clk_i) begin : out_side
    pix_out_t    want;
    int unsigned r;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_colors.size() == 0) begin
        $display("%0t ns: result with none expected, expected nothing, got %h",
                 $time, out_data);
        fails++;
      end else begin
        want = pending_colors.pop_front();
        check_field("out_red", want.out_red, out_data.out_red);
        check_field("out_green", want.out_green, out_data.out_green);
        check_field("out_blue", want.out_blue, out_data.out_blue);
      end
    end
    if (stall_left == 0) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        stall_now  = 1'b0;
        stall_left = $urandom_range(50, 200);
      end else if (r < 45) begin
        stall_now  = 1'b0;
        stall_left = $urandom_range(1, 24);
      end else if (r < 85) begin
        stall_now  = 1'b1;
        stall_left = $urandom_range(1, 3);
      end else if (r < 96) begin
        stall_now  = 1'b1;
        stall_left = $urandom_range(4, 12);
      end else begin
        stall_now  = 1'b1;
        stall_left = $urandom_range(20, 60);
      end
    end else begin
      stall_left--;
    end
    out_stall <= stall_now;
  end

  initial begin : limit
    #2_000_000;
    $display("tb_voronoi_mosaic_pixel_top NOT OK");
    $finish;
  end

  initial begin : stimulus
    logic [POS_W-1:0] pool_x [POOL_SIZE];
    logic [POS_W-1:0] pool_y [POOL_SIZE];
    pix_in_t          b;
    int unsigned      phase;
    int unsigned      n;
    int unsigned      r;
    int unsigned      idx;
    int unsigned      cnt;
    int unsigned      active;

    // Directed table. Pink rows can be read off at a glance; the rest go
    // through the predictor. Seeds 0 and 1 sit at equal distance from (1,0)
    // to exercise the lower-index tie rule, seed 255 sits at the far corner.
    push_item(mk_beat(MODE_RENDER, 8'h00, 10'd0, 10'd0, 8'h00, 8'h00, 8'h00), 1'b1, PINK);
    push_item(mk_beat(MODE_RENDER, 8'hFF, POS_MAX, POS_MAX, 8'hFF, 8'hFF, 8'hFF), 1'b1, PINK);
    push_item(mk_beat(MODE_UNUSED, 8'hFF, POS_MAX, POS_MAX, 8'hFF, 8'hFF, 8'hFF), 1'b0, PINK);
    push_item(mk_beat(MODE_LOAD, 8'd0, 10'd0, 10'd0, 8'h00, 8'h00, 8'h00), 1'b0, PINK);
    push_item(mk_beat(MODE_LOAD, 8'd1, 10'd2, 10'd0, 8'hFF, 8'hFF, 8'hFF), 1'b0, PINK);
    push_item(mk_beat(MODE_LOAD, 8'd2, 10'd5, 10'd5, 8'h00, 8'h00, 8'h00), 1'b0, PINK);
    push_item(mk_beat(MODE_LOAD, 8'd255, POS_MAX, POS_MAX, 8'h00, 8'h00, 8'h00), 1'b0, PINK);
    push_item(mk_beat(MODE_RENDER, 8'h00, 10'd512, 10'd300, 8'h00, 8'h00, 8'h00), 1'b1, PINK);
    push_cfg(9'd3);
    push_item(mk_beat(MODE_CAPTURE, 8'h00, 10'd0, 10'd0, 8'hFF, 8'hFF, 8'hFF), 1'b0, PINK);
    push_item(mk_beat(MODE_CAPTURE, 8'hFF, 10'd2, 10'd0, 8'h00, 8'h00, 8'h00), 1'b0, PINK);
    push_item(mk_beat(MODE_CAPTURE, 8'h00, 10'd5, 10'd5, 8'h12, 8'h34, 8'h56), 1'b0, PINK);
    push_item(mk_beat(MODE_CAPTURE, 8'h00, 10'd9, 10'd9, 8'hAA, 8'hBB, 8'hCC), 1'b0, PINK);
    push_item(mk_beat(MODE_RENDER, 8'h00, 10'd1, 10'd0, 8'h00, 8'h00, 8'h00), 1'b0, PINK);
    push_item(mk_beat(MODE_RENDER, 8'h00, 10'd3, 10'd0, 8'h00, 8'h00, 8'h00), 1'b0, PINK);
    push_item(mk_beat(MODE_RENDER, 8'h00, POS_MAX, POS_MAX, 8'h00, 8'h00, 8'h00), 1'b0, PINK);
    push_item(mk_beat(MODE_RENDER, 8'h00, 10'd0, 10'd0, 8'h00, 8'h00, 8'h00), 1'b0, PINK);
    // Move seed 1 onto seed 0: zero distance to both, seed 0 must win.
    push_item(mk_beat(MODE_LOAD, 8'd1, 10'd0, 10'd0, 8'h00, 8'h00, 8'h00), 1'b0, PINK);
    push_item(mk_beat(MODE_RENDER, 8'h00, 10'd0, 10'd0, 8'h00, 8'h00, 8'h00), 1'b0, PINK);
    push_cfg(9'd1);
    push_item(mk_beat(MODE_RENDER, 8'h00, POS_MAX, 10'd0, 8'h00, 8'h00, 8'h00), 1'b0, PINK);
    push_cfg(9'd0);
    push_item(mk_beat(MODE_RENDER, 8'h00, 10'd7, 10'd7, 8'h00, 8'h00, 8'h00), 1'b1, PINK);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[k]) begin
      if (rows[k].is_cfg) begin
        write_seed_count(rows[k].cfg_val);
      end else begin
        send_beat(rows[k].beat, pick_gap(), rows[k].typed, rows[k].want);
      end
    end

    // Fill every slot from a small pool of positions so a short capture pass
    // colors all of them; from here on no entry is left unwritten.
    pool_x[0] = '0;      pool_y[0] = '0;
    pool_x[1] = POS_MAX; pool_y[1] = POS_MAX;
    pool_x[2] = '0;      pool_y[2] = POS_MAX;
    pool_x[3] = POS_MAX; pool_y[3] = '0;
    for (int i = 4; i < POOL_SIZE; i++) begin
      pool_x[i] = POS_W'($urandom_range(0, POS_MAX));
      pool_y[i] = POS_W'($urandom_range(0, POS_MAX));
    end
    for (int i = 0; i < NUM_SEEDS; i++) begin
      r = $urandom_range(0, POOL_SIZE - 1);
      b = rand_beat();
      b.mode       = MODE_LOAD;
      b.seed_index = IDX_W'(i);
      b.pos_x      = pool_x[r];
      b.pos_y      = pool_y[r];
      send_beat(b, pick_gap(), 1'b0, PINK);
    end
    // Count above the slot total acts as all slots.
    write_seed_count(9'd511);
    for (int i = 0; i < POOL_SIZE; i++) begin
      b = rand_beat();
      b.mode  = MODE_CAPTURE;
      b.pos_x = pool_x[i];
      b.pos_y = pool_y[i];
      send_beat(b, pick_gap(), 1'b0, PINK);
    end
    for (int i = 0; i < 20; i++) begin
      b = rand_beat();
      b.mode  = MODE_RENDER;
      b.pos_x = rand_pos();
      b.pos_y = rand_pos();
      send_beat(b, pick_gap(), 1'b0, PINK);
    end

    // Random phases, each under its own seed count. Most beats reload or
    // recapture seeds in use and render near them; the rest is noise.
    phase = 0;
    while (beats_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (phase == 0) cnt = NUM_SEEDS;
      else if (r < 8) cnt = 0;
      else if (r < 18) cnt = $urandom_range(NUM_SEEDS, 511);
      else if (r < 30) cnt = $urandom_range(17, NUM_SEEDS - 1);
      else cnt = $urandom_range(1, 16);
      write_seed_count(COUNT_W'(cnt));
      in_steady = ($urandom_range(0, 3) == 0);
      active    = (cnt > NUM_SEEDS) ? NUM_SEEDS : cnt;
      n         = $urandom_range(20, 60);
      for (int k = 0; k < n; k++) begin
        b   = rand_beat();
        r   = $urandom_range(0, 99);
        idx = (active > 0) ? $urandom_range(0, active - 1) : $urandom_range(0, NUM_SEEDS - 1);
        if (r < 20) begin
          b.mode       = MODE_LOAD;
          b.seed_index = IDX_W'(idx);
          b.pos_x      = rand_pos();
          b.pos_y      = rand_pos();
        end else if (r < 40) begin
          b.mode = MODE_CAPTURE;
          if (r < 34) begin
            b.pos_x = seed_x[idx];
            b.pos_y = seed_y[idx];
          end else begin
            b.pos_x = rand_pos();
            b.pos_y = rand_pos();
          end
        end else if (r < 92) begin
          b.mode = MODE_RENDER;
          if (r < 60) begin
            b.pos_x = seed_x[idx] ^ POS_W'($urandom_range(0, 3));
            b.pos_y = seed_y[idx] ^ POS_W'($urandom_range(0, 3));
          end else begin
            b.pos_x = rand_pos();
            b.pos_y = rand_pos();
          end
        end else begin
          b.mode = MODE_UNUSED;
        end
        send_beat(b, pick_gap(), 1'b0, PINK);
      end
      phase++;
    end

    // Drop valid, drain every render, then let the chain run empty.
    in_valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 16) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb_voronoi_mosaic_pixel_top OK");
    end else begin
      $display("tb_voronoi_mosaic_pixel_top NOT OK");
    end
    $finish;
  end

endmodule
